FILE: hdl/rqkt_pkg.sv
// Shared types, constants and codes for the reply queue with keyed take.
`timescale 1ns / 1ps

package rqkt_pkg;

    // Number of message cells in the chain.
    localparam int QUEUE_DEPTH = 8;

    // Width of the fill counter, able to hold QUEUE_DEPTH itself.
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Width used when reporting the fill, at least the four reported bits.
    localparam int FILL_W = (CNT_W > 4) ? CNT_W : 4;

    // Operation selector carried on the input tuser.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TAKE    = 1'b1;

    // Result status carried on the output tuser.
    typedef enum logic [1:0] {
        STATUS_STORED    = 2'd0,
        STATUS_DROPPED   = 2'd1,
        STATUS_TAKEN     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    // One stored message, kind in the lowest bits.
    typedef struct packed {
        logic [31:0] arg3;
        logic [31:0] arg2;
        logic [31:0] arg1;
        logic [31:0] arg0;
        logic [31:0] reply_tag;
        logic [31:0] destination;
        logic [31:0] source;
        logic [31:0] kind;
    } msg_t;

    // Request decode shared by every cell of the chain.
    typedef struct packed {
        logic enq;
        logic take;
        logic full;
    } cell_ctl_t;

endpackage

FILE: hdl/rqkt_cell.sv
// One message cell of the queue chain: storage, key compare and shift.
`timescale 1ns / 1ps

module rqkt_cell
    import rqkt_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,        // request decode common to all cells
    input  logic      cell_valid, // this cell holds a message
    input  logic      cell_tail,  // this cell is the first free one
    input  msg_t      new_msg,    // message of an enqueue request
    input  logic [31:0] key,      // search key of a take request
    input  msg_t      next_msg,   // contents of the newer neighbour
    input  logic      hit_in,     // an older cell already matched
    output logic      hit_out,
    input  msg_t      sel_in,     // taken message gathered so far
    output msg_t      sel_out,
    output msg_t      msg         // stored contents, towards the older neighbour
);

    msg_t msg_reg;
    msg_t msg_next;
    logic match;
    logic first;

    // Key compare; only a take with a live entry may match.
    assign match   = ctl.take && cell_valid && (msg_reg.reply_tag == key);
    assign first   = match && !hit_in;
    assign hit_out = hit_in || match;
    assign sel_out = first ? msg_reg : sel_in;
    assign msg     = msg_reg;

    // Store an enqueue at the tail; shift headwards on a drop or a take's gap.
    always_comb
    begin
        msg_next = msg_reg;
        if (ctl.enq && ctl.full)
        begin
            msg_next = next_msg;
        end
        else if (ctl.enq && cell_tail)
        begin
            msg_next = new_msg;
        end
        else if (ctl.take && (hit_in || match))
        begin
            msg_next = next_msg;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg <= msg_next;
    end

endmodule

FILE: hdl/reply_queue_drop_oldest_keyed_take_core.sv
// Top level of the reply queue: chain of message cells, fill count and result register.
`timescale 1ns / 1ps
//
// Bounded queue of pending reply messages with drop-oldest and take by request id.
// The input channel (s_*) carries one request per transfer: s_tuser selects enqueue
// or take, s_tdata carries the request id (the key of a take) and the message words.
// The output channel (m_*) returns exactly one result per request: the status on
// m_tuser, the taken message and the fill after the request on m_tdata.
// Messages sit in a row of cells, oldest in the first cell. An enqueue writes the
// first free cell; when all cells are full the whole row shifts one place towards
// the head, losing the oldest message. A take compares every cell with the key,
// picks the oldest match through a priority chain, and the newer cells shift down.
// The result of an accepted request appears on m_* in the next cycle, and one
// request is taken every cycle while m_tready is high.
// The result register frees s_tready as soon as its contents are taken, so a new
// request is accepted in the same cycle a waiting result leaves. When m_tready is
// low with a result held, s_tready drops and the queue state holds.
// Reset empties the queue and clears the output valid; stored words are not cleared.
//

module reply_queue_drop_oldest_keyed_take_core
    import rqkt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // reply_tag, msg_kind, msg_source, msg_destination, msg_arg0..msg_arg3
    input  logic [255:0] s_tdata,
    // operation
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_kind, out_source, out_destination, out_reply_tag, out_arg0..out_arg3,
    // queue_fill, zero padding
    output logic [263:0] m_tdata,
    // status
    output logic [1:0]   m_tuser
);

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    msg_t             out_msg_reg;
    status_t          out_status_reg;
    status_t          status_next;
    logic [FILL_W-1:0] out_fill_reg;

    logic      accept;
    cell_ctl_t ctl;
    msg_t      new_msg;
    logic      found;

    msg_t cell_msg [QUEUE_DEPTH];
    logic hit      [QUEUE_DEPTH+1];
    msg_t sel      [QUEUE_DEPTH+1];

    // Request decode.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign new_msg.kind        = s_tdata[63:32];
    assign new_msg.source      = s_tdata[95:64];
    assign new_msg.destination = s_tdata[127:96];
    assign new_msg.reply_tag   = s_tdata[31:0];
    assign new_msg.arg0        = s_tdata[159:128];
    assign new_msg.arg1        = s_tdata[191:160];
    assign new_msg.arg2        = s_tdata[223:192];
    assign new_msg.arg3        = s_tdata[255:224];

    assign ctl.enq  = accept && (s_tuser == OP_ENQUEUE);
    assign ctl.take = accept && (s_tuser == OP_TAKE);
    assign ctl.full = (fill_reg == CNT_W'(QUEUE_DEPTH));

    // Chain of cells, oldest message in cell zero.
    assign hit[0] = 1'b0;
    assign sel[0] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        msg_t next_msg;

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_msg = new_msg;
        end
        else
        begin : g_mid
            assign next_msg = cell_msg[i+1];
        end

        rqkt_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .cell_valid (CNT_W'(i) < fill_reg),
            .cell_tail  (CNT_W'(i) == fill_reg),
            .new_msg    (new_msg),
            .key        (s_tdata[31:0]),
            .next_msg   (next_msg),
            .hit_in     (hit[i]),
            .hit_out    (hit[i+1]),
            .sel_in     (sel[i]),
            .sel_out    (sel[i+1]),
            .msg        (cell_msg[i])
        );
    end

    assign found = hit[QUEUE_DEPTH];

    // Fill count and status of the current request.
    always_comb
    begin
        fill_next   = fill_reg;
        status_next = STATUS_NOT_FOUND;
        if (ctl.enq)
        begin
            if (ctl.full)
            begin
                status_next = STATUS_DROPPED;
            end
            else
            begin
                status_next = STATUS_STORED;
                fill_next   = fill_reg + CNT_W'(1);
            end
        end
        else if (ctl.take && found)
        begin
            status_next = STATUS_TAKEN;
            fill_next   = fill_reg - CNT_W'(1);
        end
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded with each accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_msg_reg    <= sel[QUEUE_DEPTH];
            out_status_reg <= status_next;
            out_fill_reg   <= FILL_W'(fill_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'b0000, out_fill_reg[3:0], out_msg_reg};

    // The queue never holds more messages than it has cells.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count above queue depth");

    // A take that finds nothing leaves the fill unchanged.
    a_miss_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.take && !found) |=> (fill_reg == $past(fill_reg)))
        else $error("unmatched take changed the fill");

    // An enqueue into a full queue reports the drop and stays full.
    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.enq && ctl.full) |=>
            (out_status_reg == STATUS_DROPPED && fill_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("enqueue into full queue misreported");

    // Results other than a take carry no message words.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != STATUS_TAKEN) |-> (out_msg_reg == '0))
        else $error("message words present on a non-take result");

endmodule

FILE: test/reply_queue_checker.sv
// Checker for the reply queue: tracks held messages and compares every returned result.
`timescale 1ns / 1ps

module reply_queue_checker
    import rqkt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [255:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [263:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           pending
);

    // One result as the queue should return it.
    typedef struct {
        status_t     status;
        msg_t        msg;
        logic [3:0]  fill;
    } reply_t;

    // Messages currently held, oldest first.
    msg_t   held_msgs[$];
    // Results still owed by the block, oldest first.
    reply_t expected_replies[$];

    reply_t next_reply;
    reply_t seen_reply;
    msg_t   req_msg;

    initial fail_count = 0;
    initial pending = 0;

    // Apply one request to the held messages and work out its result.
    task automatic predict_reply(input logic op, input msg_t m, output reply_t r);
        int idx;
        idx = -1;
        r.status = STATUS_STORED;
        r.msg    = '0;
        if (op == OP_ENQUEUE) begin
            if (held_msgs.size() >= QUEUE_DEPTH) begin
                void'(held_msgs.pop_front());
                r.status = STATUS_DROPPED;
            end
            held_msgs.push_back(m);
        end else begin
            r.status = STATUS_NOT_FOUND;
            for (int i = 0; i < held_msgs.size(); i++) begin
                if (idx < 0 && held_msgs[i].reply_tag == m.reply_tag) begin
                    idx = i;
                end
            end
            if (idx >= 0) begin
                r.msg    = held_msgs[idx];
                r.status = STATUS_TAKEN;
                held_msgs.delete(idx);
            end
        end
        r.fill = 4'(held_msgs.size());
    endtask

    // Count a mismatched field; only the first few are described.
    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (fail_count < 10) begin
            $display("[%0t] mismatch on %s: expected %h, actual %h", $realtime, field,
                     want, got);
        end
        fail_count++;
    endtask

    // Returned results are checked before the request of the same edge is predicted,
    // since a result always belongs to an earlier request.
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                seen_reply.status = status_t'(m_tuser);
                seen_reply.msg    = msg_t'(m_tdata[255:0]);
                seen_reply.fill   = m_tdata[259:256];
                if (expected_replies.size() == 0) begin
                    note_mismatch("unexpected result", '0, m_tdata[31:0]);
                end else begin
                    next_reply = expected_replies.pop_front();
                    if (seen_reply.status !== next_reply.status)
                        note_mismatch("status", 32'(next_reply.status),
                                      32'(seen_reply.status));
                    if (seen_reply.msg.kind !== next_reply.msg.kind)
                        note_mismatch("out_kind", next_reply.msg.kind, seen_reply.msg.kind);
                    if (seen_reply.msg.source !== next_reply.msg.source)
                        note_mismatch("out_source", next_reply.msg.source,
                                      seen_reply.msg.source);
                    if (seen_reply.msg.destination !== next_reply.msg.destination)
                        note_mismatch("out_destination", next_reply.msg.destination,
                                      seen_reply.msg.destination);
                    if (seen_reply.msg.reply_tag !== next_reply.msg.reply_tag)
                        note_mismatch("out_reply_tag", next_reply.msg.reply_tag,
                                      seen_reply.msg.reply_tag);
                    if (seen_reply.msg.arg0 !== next_reply.msg.arg0)
                        note_mismatch("out_arg0", next_reply.msg.arg0, seen_reply.msg.arg0);
                    if (seen_reply.msg.arg1 !== next_reply.msg.arg1)
                        note_mismatch("out_arg1", next_reply.msg.arg1, seen_reply.msg.arg1);
                    if (seen_reply.msg.arg2 !== next_reply.msg.arg2)
                        note_mismatch("out_arg2", next_reply.msg.arg2, seen_reply.msg.arg2);
                    if (seen_reply.msg.arg3 !== next_reply.msg.arg3)
                        note_mismatch("out_arg3", next_reply.msg.arg3, seen_reply.msg.arg3);
                    if (seen_reply.fill !== next_reply.fill)
                        note_mismatch("queue_fill", 32'(next_reply.fill),
                                      32'(seen_reply.fill));
                end
            end
            if (s_tvalid && s_tready) begin
                // The request tdata carries the id first, then the message words.
                req_msg.reply_tag   = s_tdata[31:0];
                req_msg.kind        = s_tdata[63:32];
                req_msg.source      = s_tdata[95:64];
                req_msg.destination = s_tdata[127:96];
                req_msg.arg0        = s_tdata[159:128];
                req_msg.arg1        = s_tdata[191:160];
                req_msg.arg2        = s_tdata[223:192];
                req_msg.arg3        = s_tdata[255:224];
                predict_reply(s_tuser, req_msg, next_reply);
                expected_replies.push_back(next_reply);
            end
            pending = expected_replies.size();
        end
    end

endmodule

FILE: test/tb_top.sv
// Testbench top for the reply queue: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top
    import rqkt_pkg::*;
();

    localparam int RANDOM_REQUESTS = 933;
    localparam int CYCLE_LIMIT     = 200000;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata  = '0;
    logic         s_tuser  = OP_ENQUEUE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [263:0] m_tdata;
    logic [1:0]   m_tuser;

    int          fail_count;
    int          pending;
    int          send_idle_pct = 33;
    int          recv_idle_pct = 79;
    int          cycle_count   = 0;
    logic [31:0] id_pool[8];

    reply_queue_drop_oldest_keyed_take_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    reply_queue_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Free-running clock.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Result side: ready drops at random according to the current idle rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Message with the given id and random words.
    function automatic msg_t random_msg(input logic [31:0] id);
        msg_t m;
        m.reply_tag   = id;
        m.kind        = $urandom;
        m.source      = $urandom;
        m.destination = $urandom;
        m.arg0        = $urandom;
        m.arg1        = $urandom;
        m.arg2        = $urandom;
        m.arg3        = $urandom;
        return m;
    endfunction

    // Offer one request, with random idle cycles first, and wait until it is taken.
    task automatic send_request(input logic op, input msg_t m);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {m.arg3, m.arg2, m.arg1, m.arg0,
                     m.destination, m.source, m.kind, m.reply_tag};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] id_a;
        logic [31:0] id_c;
        logic [31:0] id_g;
        logic        op;
        logic [31:0] id;

        id_a = 32'hA5A5_0001;
        id_c = 32'h5A5A_C003;
        id_g = 32'h0F0F_6007;
        for (int i = 0; i < 8; i++)
            id_pool[i] = $urandom;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Take on an empty queue, then the all-zero and all-one messages.
        send_request(OP_TAKE, random_msg(32'h0));
        send_request(OP_ENQUEUE, '0);
        send_request(OP_ENQUEUE, '1);
        send_request(OP_TAKE, random_msg(32'hFFFF_FFFF));
        // Key that matches nothing held.
        send_request(OP_TAKE, random_msg(32'h1234_5678));

        // Fill the queue, with a duplicate id, then overflow it so the oldest is lost.
        send_request(OP_ENQUEUE, random_msg(id_a));
        send_request(OP_ENQUEUE, random_msg(32'hB0B0_B002));
        send_request(OP_ENQUEUE, random_msg(id_a));
        send_request(OP_ENQUEUE, random_msg(id_c));
        send_request(OP_ENQUEUE, random_msg(32'hD0D0_D004));
        send_request(OP_ENQUEUE, random_msg(32'hE0E0_E005));
        send_request(OP_ENQUEUE, random_msg(32'hF0F0_F006));
        send_request(OP_ENQUEUE, random_msg(id_g));

        // Oldest of two duplicates, one from the middle, the newest, the other duplicate.
        send_request(OP_TAKE, random_msg(id_a));
        send_request(OP_TAKE, random_msg(id_c));
        send_request(OP_TAKE, random_msg(id_g));
        send_request(OP_TAKE, random_msg(id_a));

        // Random traffic over a small id pool so that takes often hit.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 3) begin
                send_idle_pct = 79;
                recv_idle_pct = 33;
            end else if (n == 2 * RANDOM_REQUESTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            op = ($urandom_range(99) < 58) ? OP_ENQUEUE : OP_TAKE;
            id = ($urandom_range(99) < 88) ? id_pool[$urandom_range(7)] : $urandom;
            send_request(op, random_msg(id));
        end
        s_tvalid <= 1'b0;

        // Let the checker record the last request before watching the drain.
        @(posedge clk);

        // Drain the outstanding results, then keep watching for stray ones.
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
